[src/csv_record_field_splitter_assert.svh]
// Assertion macros shared by the CSV record field splitter.
`ifndef CSV_RECORD_FIELD_SPLITTER_ASSERT_SVH
`define CSV_RECORD_FIELD_SPLITTER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CSVS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("CSV splitter check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CSVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("CSV splitter check failed");

`endif

[src/csvs_pkg.sv]
// Shared types and codes for the CSV record field splitter.
package csvs_pkg;

  localparam logic [1:0] OP_BYTE      = 2'd0;
  localparam logic [1:0] OP_BYTE_LAST = 2'd1;
  localparam logic [1:0] OP_END       = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR  = 3'd1;
  localparam logic [2:0] ERR_UNTERM    = 3'd2;
  localparam logic [2:0] ERR_JUNK      = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

  localparam logic REG_RFC_MODE  = 1'b0;
  localparam logic REG_SEPARATOR = 1'b1;

  localparam logic [7:0] SEPARATOR_RESET = 8'h2C;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       field_end;
    logic       record_end;
    logic [2:0] error_code;
  } result_t;

  typedef struct packed {
    logic       hold_wr;
    logic       flush;
    logic       flush_bytes;
    logic       hold_clr;
    logic       has_main;
    result_t    main;
    logic       has_end;
    logic [2:0] end_err;
  } cmd_t;

endpackage

[src/csvs_front.sv]
// Front end: accepts record bytes, tracks parse state and issues commands.
module csvs_front #(
  parameter int WS_HOLD_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rfc_mode,
  input  logic [7:0]    separator,
  input  logic          accept,
  input  logic [1:0]    op,
  input  logic [7:0]    data_byte,
  output logic          push,
  output csvs_pkg::cmd_t cmd
);
  import csvs_pkg::*;

  localparam int CW = $clog2(WS_HOLD_DEPTH + 1);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_IN     = 3'd1,
    PH_QUOTED = 3'd2,
    PH_QQ     = 3'd3,
    PH_START  = 3'd4
  } phase_t;

  phase_t          phase;
  phase_t          phase_next;
  phase_t          ph_simple;
  logic [CW-1:0]   held_count;
  logic [CW-1:0]   held_count_next;
  logic            cr_pending;
  logic            cr_pending_next;
  logic [2:0]      record_error;
  logic [2:0]      record_error_next;
  logic [2:0]      end_err;
  logic            is_space;
  logic            is_byte;
  logic            is_last;
  logic            ends;

  assign is_space = (data_byte == CH_SPACE) || (data_byte == CH_TAB) ||
                    (data_byte == CH_CR) || (data_byte == CH_LF);
  assign is_byte  = (op == OP_BYTE) || (op == OP_BYTE_LAST);
  assign is_last  = (op == OP_BYTE_LAST);
  assign ends     = (op != OP_BYTE);
  assign ph_simple = ((phase == PH_QUOTED) || (phase == PH_QQ)) ? PH_IN : phase;

  always_comb begin
    cmd               = '0;
    phase_next        = phase;
    held_count_next   = held_count;
    cr_pending_next   = cr_pending;
    record_error_next = record_error;
    end_err           = ERR_NONE;
    if (is_byte && (record_error == ERR_NONE)) begin
      if (!rfc_mode) begin
        if (is_space) begin
          if ((ph_simple == PH_FIRST) ||
              ((ph_simple == PH_START) && (data_byte != separator))) begin
            cmd.hold_wr = 1'b0;
          end else if (held_count == CW'(WS_HOLD_DEPTH)) begin
            record_error_next = ERR_OVERFLOW;
          end else begin
            cmd.hold_wr     = 1'b1;
            cmd.main.data   = data_byte;
            held_count_next = held_count + CW'(1);
          end
        end else begin
          cmd.flush       = 1'b1;
          cmd.flush_bytes = (ph_simple == PH_IN) && (data_byte != separator);
          cmd.has_main    = 1'b1;
          held_count_next = '0;
          if (data_byte == separator) begin
            cmd.main.field_end = 1'b1;
            phase_next         = PH_START;
          end else begin
            cmd.main.data       = data_byte;
            cmd.main.byte_valid = 1'b1;
            phase_next          = PH_IN;
          end
        end
      end else if (cr_pending) begin
        cr_pending_next = 1'b0;
        if (!((data_byte == CH_LF) && is_last)) begin
          record_error_next = (phase == PH_QQ) ? ERR_JUNK : ERR_BAD_CHAR;
        end
      end else if (phase == PH_QUOTED) begin
        if (data_byte == CH_QUOTE) begin
          phase_next = PH_QQ;
        end else begin
          cmd.has_main        = 1'b1;
          cmd.main.data       = data_byte;
          cmd.main.byte_valid = 1'b1;
        end
      end else if (phase == PH_QQ) begin
        if (data_byte == CH_QUOTE) begin
          phase_next          = PH_QUOTED;
          cmd.has_main        = 1'b1;
          cmd.main.data       = data_byte;
          cmd.main.byte_valid = 1'b1;
        end else if (data_byte == CH_COMMA) begin
          phase_next         = PH_START;
          cmd.has_main       = 1'b1;
          cmd.main.field_end = 1'b1;
        end else if (data_byte == CH_CR) begin
          cr_pending_next = 1'b1;
        end else begin
          record_error_next = ERR_JUNK;
        end
      end else if (data_byte == CH_CR) begin
        cr_pending_next = 1'b1;
      end else if ((data_byte < CH_SPACE) || (data_byte > CH_TILDE)) begin
        record_error_next = ERR_BAD_CHAR;
      end else if (data_byte == CH_COMMA) begin
        phase_next         = PH_START;
        cmd.has_main       = 1'b1;
        cmd.main.field_end = 1'b1;
      end else if ((data_byte == CH_QUOTE) && (phase != PH_IN)) begin
        phase_next = PH_QUOTED;
      end else begin
        phase_next          = PH_IN;
        cmd.has_main        = 1'b1;
        cmd.main.data       = data_byte;
        cmd.main.byte_valid = 1'b1;
      end
    end
    if (ends) begin
      end_err = record_error_next;
      if ((record_error_next == ERR_NONE) && rfc_mode) begin
        if (cr_pending_next) begin
          end_err = (phase_next == PH_QQ) ? ERR_JUNK : ERR_BAD_CHAR;
        end else if (phase_next == PH_QUOTED) begin
          end_err = ERR_UNTERM;
        end
      end
      if (is_last && cmd.has_main && cmd.main.byte_valid && (end_err == ERR_NONE)) begin
        cmd.main.field_end  = 1'b1;
        cmd.main.record_end = 1'b1;
      end else begin
        cmd.has_end = 1'b1;
        cmd.end_err = end_err;
      end
      cmd.hold_wr       = 1'b0;
      cmd.hold_clr      = 1'b1;
      phase_next        = PH_FIRST;
      held_count_next   = '0;
      cr_pending_next   = 1'b0;
      record_error_next = ERR_NONE;
    end
  end

  assign push = accept && (cmd.hold_wr || cmd.has_main || cmd.has_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FIRST;
      held_count   <= '0;
      cr_pending   <= 1'b0;
      record_error <= ERR_NONE;
    end else if (accept) begin
      phase        <= phase_next;
      held_count   <= held_count_next;
      cr_pending   <= cr_pending_next;
      record_error <= record_error_next;
    end
  end

endmodule

[src/csvs_queue.sv]
// Two-entry command queue between the front and back ends.
module csvs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  csvs_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           head_valid,
  output csvs_pkg::cmd_t head_cmd,
  output logic           full
);
  import csvs_pkg::*;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  cmd_t           slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           do_push;
  logic           do_pop;

  assign full       = (count == QCW'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCW'(1);
      end
    end
  end

endmodule

[src/csvs_back.sv]
// Back end: holds inner whitespace and drives the result register.
module csvs_back #(
  parameter int WS_HOLD_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     separator,
  input  logic           head_valid,
  input  csvs_pkg::cmd_t head_cmd,
  output logic           pop,
  output logic           result_valid,
  input  logic           result_stall,
  output logic [7:0]     out_byte,
  output logic           byte_valid,
  output logic           field_end,
  output logic           record_end,
  output logic [2:0]     error_code
);
  import csvs_pkg::*;

  localparam int CW = $clog2(WS_HOLD_DEPTH + 1);
  localparam int AW = (WS_HOLD_DEPTH > 1) ? $clog2(WS_HOLD_DEPTH) : 1;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_SEPS,
    B_HELD,
    B_MAIN,
    B_END
  } back_state_t;

  back_state_t   state;
  cmd_t          cmd;
  logic [7:0]    held_space [WS_HOLD_DEPTH];
  logic [7:0]    rd_data;
  logic [CW-1:0] ptr;
  logic [CW-1:0] idx;
  logic [CW-1:0] seps;
  logic          dat_ok;
  logic          load_ok;
  logic          head_flush_busy;
  logic          head_needs_out;
  logic          rd_issue;
  logic          mem_we;

  assign load_ok         = !result_valid || !result_stall;
  assign head_flush_busy = head_cmd.flush && (ptr != '0);
  assign head_needs_out  = head_cmd.has_main || head_cmd.has_end;
  assign pop = (state == B_IDLE) && head_valid &&
               (head_flush_busy || !head_needs_out || load_ok);
  assign mem_we   = pop && head_cmd.hold_wr;
  assign rd_issue = ((state == B_SCAN) && (idx < ptr)) ||
                    ((state == B_HELD) && !dat_ok);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      held_space[ptr[AW-1:0]] <= head_cmd.main.data;
    end
    if (rd_issue) begin
      rd_data <= held_space[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      ptr          <= '0;
      dat_ok       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop) begin
            if (head_cmd.hold_wr) begin
              ptr <= ptr + CW'(1);
            end
            if (head_flush_busy) begin
              cmd   <= head_cmd;
              idx   <= '0;
              seps  <= '0;
              state <= B_SCAN;
            end else begin
              if (head_cmd.hold_clr || head_cmd.flush) begin
                ptr <= '0;
              end
              if (head_cmd.has_main) begin
                result_valid <= 1'b1;
                out_byte     <= head_cmd.main.data;
                byte_valid   <= head_cmd.main.byte_valid;
                field_end    <= head_cmd.main.field_end;
                record_end   <= head_cmd.main.record_end;
                error_code   <= head_cmd.main.error_code;
                if (head_cmd.has_end) begin
                  cmd   <= head_cmd;
                  state <= B_END;
                end
              end else if (head_cmd.has_end) begin
                result_valid <= 1'b1;
                out_byte     <= '0;
                byte_valid   <= 1'b0;
                field_end    <= 1'b1;
                record_end   <= 1'b1;
                error_code   <= head_cmd.end_err;
              end
            end
          end
        end
        B_SCAN: begin
          dat_ok <= rd_issue;
          if (rd_issue) begin
            idx <= idx + CW'(1);
          end
          if (dat_ok && (rd_data == separator)) begin
            seps <= seps + CW'(1);
          end
          if (!rd_issue && !dat_ok) begin
            idx <= '0;
            if (seps != '0) begin
              state <= B_SEPS;
            end else if (cmd.flush_bytes) begin
              state <= B_HELD;
            end else begin
              ptr   <= '0;
              state <= B_MAIN;
            end
          end
        end
        B_SEPS: begin
          if (load_ok) begin
            result_valid <= 1'b1;
            out_byte     <= '0;
            byte_valid   <= 1'b0;
            field_end    <= 1'b1;
            record_end   <= 1'b0;
            error_code   <= ERR_NONE;
            seps         <= seps - CW'(1);
            if (seps == CW'(1)) begin
              ptr   <= '0;
              state <= B_MAIN;
            end
          end
        end
        B_HELD: begin
          if (!dat_ok) begin
            dat_ok <= 1'b1;
          end else if (load_ok) begin
            result_valid <= 1'b1;
            out_byte     <= rd_data;
            byte_valid   <= 1'b1;
            field_end    <= 1'b0;
            record_end   <= 1'b0;
            error_code   <= ERR_NONE;
            dat_ok       <= 1'b0;
            idx          <= idx + CW'(1);
            if ((idx + CW'(1)) == ptr) begin
              ptr   <= '0;
              state <= B_MAIN;
            end
          end
        end
        B_MAIN: begin
          if (!cmd.has_main) begin
            state <= cmd.has_end ? B_END : B_IDLE;
          end else if (load_ok) begin
            result_valid <= 1'b1;
            out_byte     <= cmd.main.data;
            byte_valid   <= cmd.main.byte_valid;
            field_end    <= cmd.main.field_end;
            record_end   <= cmd.main.record_end;
            error_code   <= cmd.main.error_code;
            state        <= cmd.has_end ? B_END : B_IDLE;
          end
        end
        B_END: begin
          if (load_ok) begin
            result_valid <= 1'b1;
            out_byte     <= '0;
            byte_valid   <= 1'b0;
            field_end    <= 1'b1;
            record_end   <= 1'b1;
            error_code   <= cmd.end_err;
            state        <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

[src/csv_record_field_splitter.sv]
// Top level of the CSV record field splitter.
// Record bytes arrive one beat at a time on op and data_byte, qualified by
// item_valid and held back by item_stall. Field bytes and field and record
// end marks leave one beat at a time on the result channel, qualified by
// result_valid and held by result_stall. The configuration channel writes
// rfc_mode (index 0) or separator (index 1) from cfg_data; cfg_ready is high.
// A beat that yields a single result passes through the command queue and
// the result register, and such beats flow at one per cycle while the
// receiver does not stall. A non-space byte that follows n held whitespace
// bytes first scans the hold memory, then emits one field end per cycle
// for each held separator while not stalled, or else each held byte of the
// field, so the hold memory read loop sets the cost of a flush. Reset clears
// the parse state and sets rfc_mode to 0 and separator to a comma. While the
// receiver stalls, the result register holds its beat, the two-entry command
// queue fills, and item_stall rises once the queue is full.
module csv_record_field_splitter #(
  parameter int WS_HOLD_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] op,
  input  logic [7:0] data_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       field_end,
  output logic       record_end,
  output logic [2:0] error_code,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import csvs_pkg::*;

  `include "csv_record_field_splitter_assert.svh"

  logic       rfc_mode;
  logic [7:0] separator;
  logic       accept;
  logic       push;
  cmd_t       push_cmd;
  logic       pop;
  logic       head_valid;
  cmd_t       head_cmd;
  logic       full;

  assign cfg_ready  = 1'b1;
  assign item_stall = full;
  assign accept     = item_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      rfc_mode  <= 1'b0;
      separator <= SEPARATOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RFC_MODE:  rfc_mode  <= cfg_data[0];
        REG_SEPARATOR: separator <= cfg_data;
        default: begin
          rfc_mode <= rfc_mode;
        end
      endcase
    end
  end

  csvs_front #(
    .WS_HOLD_DEPTH(WS_HOLD_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .rfc_mode  (rfc_mode),
    .separator (separator),
    .accept    (accept),
    .op        (op),
    .data_byte (data_byte),
    .push      (push),
    .cmd       (push_cmd)
  );

  csvs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .full       (full)
  );

  csvs_back #(
    .WS_HOLD_DEPTH(WS_HOLD_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .separator    (separator),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .field_end    (field_end),
    .record_end   (record_end),
    .error_code   (error_code)
  );

  `CSVS_ASSERT_NOW(a_record_end_ends_field, clk, rst,
    result_valid && record_end, field_end)
  `CSVS_ASSERT_NOW(a_error_only_on_bare_end, clk, rst,
    result_valid && (error_code != ERR_NONE), record_end && !byte_valid)
  `CSVS_ASSERT_NOW(a_mark_carries_zero_byte, clk, rst,
    result_valid && !byte_valid, out_byte == 8'h00)
  `CSVS_ASSERT_NEXT(a_stalled_beat_holds, clk, rst,
    result_valid && result_stall,
    result_valid && $stable({out_byte, byte_valid, field_end, record_end, error_code}))

endmodule

[tb/csv_record_field_splitter_tb.sv]
// Self-checking testbench that streams CSV record beats and checks each result beat.
`timescale 1ns / 100ps

module csv_record_field_splitter_tb;
  import csvs_pkg::*;

  localparam int WS_DEPTH = 16;
  localparam int SETTLE_CYCLES = 80;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_LIMIT = 50;

  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_UNQUOTED,
    PH_QUOTED,
    PH_QUOTE_SEEN,
    PH_NEXT_FIELD
  } parse_phase_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } rec_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] op = OP_BYTE;
  logic [7:0] data_byte = 8'h00;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [7:0] out_byte;
  logic byte_valid;
  logic field_end;
  logic record_end;
  logic [2:0] error_code;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_RFC_MODE;
  logic [7:0] cfg_data = 8'h00;

  csv_record_field_splitter #(
    .WS_HOLD_DEPTH(WS_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .op(op),
    .data_byte(data_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_byte(out_byte),
    .byte_valid(byte_valid),
    .field_end(field_end),
    .record_end(record_end),
    .error_code(error_code),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser state mirrored from the block's behavior.
  logic cur_rfc = 1'b0;
  logic [7:0] cur_sep = SEPARATOR_RESET;
  parse_phase_t cur_phase = PH_FIRST;
  logic [7:0] ws_held [WS_DEPTH];
  int ws_count = 0;
  logic cr_wait = 1'b0;
  logic [2:0] rec_err = ERR_NONE;

  result_t beat_results[$];
  result_t split_results_q[$];
  rec_beat_t pending_beats[$];
  rec_beat_t next_beat;
  logic [7:0] rec_bytes[$];

  int queued_total = 0;
  int beats_taken = 0;
  int results_seen = 0;
  int records_seen = 0;
  int error_records = 0;
  int mismatches = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;

  function automatic logic [7:0] rand_byte(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(hi, lo);
    return r[7:0];
  endfunction

  function automatic logic [7:0] ws_byte();
    case ($urandom_range(3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic is_ws(logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
  endfunction

  function automatic void add_result(logic [7:0] d, logic bv, logic fe, logic re,
                                     logic [2:0] err);
    result_t r;
    r.data = d;
    r.byte_valid = bv;
    r.field_end = fe;
    r.record_end = re;
    r.error_code = err;
    beat_results.push_back(r);
  endfunction

  function automatic void split_simple(logic [7:0] b);
    parse_phase_t ph;
    int seps;
    int i;
    ph = cur_phase;
    if (ph == PH_QUOTED || ph == PH_QUOTE_SEEN) ph = PH_UNQUOTED;
    if (is_ws(b)) begin
      if (ph == PH_FIRST || (ph == PH_NEXT_FIELD && b != cur_sep)) return;
      if (ws_count >= WS_DEPTH) begin
        rec_err = ERR_OVERFLOW;
        return;
      end
      ws_held[ws_count] = b;
      ws_count++;
      return;
    end
    seps = 0;
    for (i = 0; i < ws_count; i++)
      if (ws_held[i] == cur_sep) seps++;
    for (i = 0; i < seps; i++)
      add_result(8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
    if (seps == 0 && ph == PH_UNQUOTED && b != cur_sep)
      for (i = 0; i < ws_count; i++)
        add_result(ws_held[i], 1'b1, 1'b0, 1'b0, ERR_NONE);
    ws_count = 0;
    if (b == cur_sep) begin
      add_result(8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
      cur_phase = PH_NEXT_FIELD;
    end else begin
      add_result(b, 1'b1, 1'b0, 1'b0, ERR_NONE);
      cur_phase = PH_UNQUOTED;
    end
  endfunction

  function automatic void split_rfc(logic [7:0] b, logic last);
    if (cr_wait) begin
      cr_wait = 1'b0;
      if (b == CH_LF && last) return;
      rec_err = (cur_phase == PH_QUOTE_SEEN) ? ERR_JUNK : ERR_BAD_CHAR;
      return;
    end
    case (cur_phase)
      PH_QUOTED: begin
        if (b == CH_QUOTE) cur_phase = PH_QUOTE_SEEN;
        else add_result(b, 1'b1, 1'b0, 1'b0, ERR_NONE);
      end
      PH_QUOTE_SEEN: begin
        if (b == CH_QUOTE) begin
          cur_phase = PH_QUOTED;
          add_result(b, 1'b1, 1'b0, 1'b0, ERR_NONE);
        end else if (b == CH_COMMA) begin
          cur_phase = PH_NEXT_FIELD;
          add_result(8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
        end else if (b == CH_CR) begin
          cr_wait = 1'b1;
        end else begin
          rec_err = ERR_JUNK;
        end
      end
      default: begin
        if (b == CH_CR) begin
          cr_wait = 1'b1;
        end else if (b < CH_PRINT_LO || b > CH_PRINT_HI) begin
          rec_err = ERR_BAD_CHAR;
        end else if (b == CH_COMMA) begin
          cur_phase = PH_NEXT_FIELD;
          add_result(8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
        end else if (b == CH_QUOTE && cur_phase != PH_UNQUOTED) begin
          cur_phase = PH_QUOTED;
        end else begin
          cur_phase = PH_UNQUOTED;
          add_result(b, 1'b1, 1'b0, 1'b0, ERR_NONE);
        end
      end
    endcase
  endfunction

  function automatic void split_beat(logic [1:0] op_in, logic [7:0] b);
    logic last;
    result_t r;
    int i;
    beat_results.delete();
    last = (op_in == OP_BYTE_LAST);
    if ((op_in == OP_BYTE || last) && rec_err == ERR_NONE) begin
      if (cur_rfc) split_rfc(b, last);
      else split_simple(b);
    end
    if (op_in != OP_BYTE) begin
      if (rec_err == ERR_NONE && cur_rfc) begin
        if (cr_wait) rec_err = (cur_phase == PH_QUOTE_SEEN) ? ERR_JUNK : ERR_BAD_CHAR;
        else if (cur_phase == PH_QUOTED) rec_err = ERR_UNTERM;
      end
      if (last && beat_results.size() != 0 && rec_err == ERR_NONE &&
          beat_results[beat_results.size() - 1].byte_valid) begin
        r = beat_results.pop_back();
        r.field_end = 1'b1;
        r.record_end = 1'b1;
        beat_results.push_back(r);
      end else begin
        add_result(8'h00, 1'b0, 1'b1, 1'b1, rec_err);
      end
      cur_phase = PH_FIRST;
      ws_count = 0;
      cr_wait = 1'b0;
      rec_err = ERR_NONE;
    end
    for (i = 0; i < beat_results.size(); i++)
      split_results_q.push_back(beat_results[i]);
  endfunction

  function automatic void push_beat(logic [1:0] op_in, logic [7:0] b);
    rec_beat_t t;
    t.op = op_in;
    t.data = b;
    pending_beats.push_back(t);
    queued_total++;
  endfunction

  function automatic void push_text(string s, logic ends_record);
    int i;
    for (i = 0; i < s.len(); i++)
      push_beat((ends_record && i == s.len() - 1) ? OP_BYTE_LAST : OP_BYTE, s[i]);
  endfunction

  function automatic void finish_record(logic rfc);
    int t;
    int i;
    t = $urandom_range(9);
    if (rfc && t < 4) begin
      rec_bytes.push_back(CH_CR);
      rec_bytes.push_back(CH_LF);
    end
    if (t < 6 && rec_bytes.size() != 0) begin
      for (i = 0; i < rec_bytes.size() - 1; i++) push_beat(OP_BYTE, rec_bytes[i]);
      push_beat(OP_BYTE_LAST, rec_bytes[rec_bytes.size() - 1]);
    end else begin
      for (i = 0; i < rec_bytes.size(); i++) push_beat(OP_BYTE, rec_bytes[i]);
      push_beat((t == 9) ? OP_RESERVED : OP_END, rand_byte(0, 255));
    end
    rec_bytes.delete();
  endfunction

  function automatic void add_simple_record();
    int len;
    int i;
    int pick;
    len = $urandom_range(12, 1);
    for (i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) rec_bytes.push_back(rand_byte(8'h21, 8'h7E));
      else if (pick < 65) rec_bytes.push_back(ws_byte());
      else if (pick < 80) rec_bytes.push_back(cur_sep);
      else rec_bytes.push_back(rand_byte(0, 255));
    end
    if ($urandom_range(7) == 0)
      repeat ($urandom_range(20, 12)) rec_bytes.insert(1, ws_byte());
    finish_record(1'b0);
  endfunction

  function automatic void add_rfc_record();
    int nf;
    int f;
    int len;
    int i;
    int pick;
    logic [7:0] b;
    nf = $urandom_range(4, 1);
    for (f = 0; f < nf; f++) begin
      if (f != 0) rec_bytes.push_back(CH_COMMA);
      len = $urandom_range(6);
      if ($urandom_range(2) == 0) begin
        rec_bytes.push_back(CH_QUOTE);
        for (i = 0; i < len; i++) begin
          pick = $urandom_range(99);
          if (pick < 15) begin
            rec_bytes.push_back(CH_QUOTE);
            rec_bytes.push_back(CH_QUOTE);
          end else if (pick < 25) begin
            rec_bytes.push_back(CH_COMMA);
          end else if (pick < 35) begin
            rec_bytes.push_back(pick[0] ? CH_CR : CH_LF);
          end else begin
            b = rand_byte(0, 255);
            rec_bytes.push_back((b == CH_QUOTE) ? 8'h71 : b);
          end
        end
        rec_bytes.push_back(CH_QUOTE);
      end else begin
        for (i = 0; i < len; i++) begin
          b = rand_byte(CH_PRINT_LO, CH_PRINT_HI);
          rec_bytes.push_back((b == CH_QUOTE || b == CH_COMMA) ? 8'h75 : b);
        end
      end
    end
    if ($urandom_range(6) == 0)
      rec_bytes.insert($urandom_range(rec_bytes.size()), rand_byte(0, 255));
    finish_record(1'b1);
  endfunction

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    end
  endfunction

  // Input beats: taken from the pending queue with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        split_beat(op, data_byte);
        beats_taken++;
      end
      if (!item_valid || !item_stall) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= gap_pct) begin
          next_beat = pending_beats.pop_front();
          item_valid <= 1'b1;
          op <= next_beat.op;
          data_byte <= next_beat.data;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off, started each time hold_req changes.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result beats: compared in order against the expected stream.
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (record_end) records_seen++;
        if (record_end && error_code != ERR_NONE) error_records++;
        if (split_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result beat, expected none, actual 0x%0h %0b %0b %0b %0d",
                     $time, out_byte, byte_valid, field_end, record_end, error_code);
        end else begin
          want = split_results_q.pop_front();
          check_field("out_byte", want.data, out_byte);
          check_field("byte_valid", want.byte_valid, byte_valid);
          check_field("field_end", want.field_end, field_end);
          check_field("record_end", want.record_end, record_end);
          check_field("error_code", want.error_code, error_code);
        end
      end
      result_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d result beats outstanding", $time,
               split_results_q.size());
      $display("csv_record_field_splitter_tb: FAIL");
      $finish;
    end
  end

  task automatic settle();
    while (pending_beats.size() != 0 || item_valid || split_results_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_RFC_MODE) cur_rfc = val[0];
    else cur_sep = val;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(logic rfc, logic [7:0] sep, int gaps, int stalls, int n);
    logic [7:0] v;
    int start;
    v = rand_byte(0, 255);
    v[0] = rfc;
    write_reg(REG_RFC_MODE, v);
    write_reg(REG_SEPARATOR, sep);
    gap_pct = gaps;
    stall_pct = stalls;
    start = queued_total;
    while (queued_total - start < n) begin
      if (rfc) add_rfc_record();
      else add_simple_record();
    end
    settle();
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Simple split with trimming, byte extremes and both end-only opcodes.
    push_text(" a ,b ", 1'b1);
    push_beat(OP_BYTE, 8'h00);
    push_beat(OP_BYTE_LAST, 8'hFF);
    push_beat(OP_END, 8'hA5);
    push_beat(OP_RESERVED, 8'h5A);
    settle();

    // Quoted field with a doubled quote, trailing comma, CRLF, then each RFC-mode error.
    write_reg(REG_RFC_MODE, 8'h01);
    push_text("\"a\"\"\",\x0D\x0A", 1'b1);
    push_beat(OP_BYTE_LAST, 8'h7F);
    push_text("\"", 1'b1);
    push_text("\"\"x", 1'b1);
    settle();

    run_phase(1'b0, CH_COMMA, 0, 0, 6);
    run_phase(1'b1, CH_COMMA, 69, 0, 6);
    run_phase(1'b0, CH_SPACE, 0, 69, 6);
    run_phase(1'b1, 8'h00, 7, 7, 6);
    run_phase(1'b0, 8'hFF, 7, 7, 6);

    // Receiver holds off while the sender keeps going; includes a hold overflow.
    write_reg(REG_RFC_MODE, 8'h00);
    write_reg(REG_SEPARATOR, CH_SEMI);
    gap_pct = 0;
    stall_pct = 0;
    hold_req++;
    push_beat(OP_BYTE, 8'h61);
    repeat (WS_DEPTH + 2) push_beat(OP_BYTE, CH_SPACE);
    push_beat(OP_BYTE_LAST, 8'h62);
    push_text("c;d e;f", 1'b1);
    settle();

    // Mode switches in the middle of a record.
    write_reg(REG_RFC_MODE, 8'h01);
    push_text("\"a", 1'b0);
    settle();
    write_reg(REG_RFC_MODE, 8'h00);
    push_text("b c", 1'b1);
    push_text("x ", 1'b0);
    settle();
    write_reg(REG_RFC_MODE, 8'h01);
    push_text("y", 1'b1);
    push_text("z\x0D", 1'b0);
    settle();
    write_reg(REG_RFC_MODE, 8'h00);
    push_text("w", 1'b1);
    settle();

    $display("Sent %0d record beats; checked %0d result beats over %0d records, %0d with errors.",
             beats_taken, results_seen, records_seen, error_records);
    $display("Both parse modes, comma, space and 0xFF separators, gaps, stalls and a long hold.");
    if (mismatches == 0 && split_results_q.size() == 0) begin
      $display("csv_record_field_splitter_tb: PASS");
    end else begin
      $display("csv_record_field_splitter_tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/csvs_pkg.sv
src/csvs_front.sv
src/csvs_queue.sv
src/csvs_back.sv
src/csv_record_field_splitter.sv
tb/csv_record_field_splitter_tb.sv
